### sv/scalar_kalman_filter_core_defines.svh
// Assertion macros for the scalar Kalman filter core.
`ifndef SCALAR_KALMAN_FILTER_CORE_DEFINES_SVH
`define SCALAR_KALMAN_FILTER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge out of reset.
`define SKF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Condition must never be true out of reset.
`define SKF_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define SKF_ASSERT(lbl, prop, msg)
`define SKF_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

### sv/skf_pkg.sv
// Shared constants and types of the scalar Kalman filter core.
`timescale 1ns / 1ps
package skf_pkg;

  localparam int W          = 32;  // data word width
  localparam int F          = 16;  // fraction bits
  localparam int CFG_ADDR_W = 2;
  localparam int CNT_W      = $clog2(W);
  localparam int RSH_W      = 2 * W + 1 - F;

  localparam logic [W-1:0] UMAX  = {W{1'b1}};
  localparam logic [W-1:0] SMAX  = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] SMIN  = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] ONE_Q = W'(1) << F;

  localparam logic [W-1:0] A_RESET   = ONE_Q;
  localparam logic [W-1:0] H_RESET   = ONE_Q;
  localparam logic [W-1:0] Q_RESET   = '0;
  localparam logic [W-1:0] R_RESET   = W'(3) << F;
  localparam logic [W-1:0] VAR_RESET = W'(50) << F;

  localparam logic [2*W:0] RND_HALF = (2 * W + 1)'(1) << (F - 1);

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_TRANSITION = 2'd0,
    REG_MEASURE    = 2'd1,
    REG_PNOISE     = 2'd2,
    REG_MNOISE     = 2'd3
  } cfg_reg_e;

endpackage

### sv/scalar_kalman_filter_core.sv
// Top level of the scalar Kalman filter core (sequencer and shared datapath).
// Usage:
//   s_axis_* carries one measurement z (signed Q16.16) per transaction.
//   m_axis_* carries one result per measurement: estimate x, variance P, gain K.
//   cfg_* writes A, H, Q, R (index 0..3); write only while idle.
// Datapath:
//   One 32x32 multiplier, shared by all products, and one restoring
//   divider for the gain run under a sequencer. The gain divide has 32
//   steps. A zero denominator skips the divide, and a quotient of 2^32 or
//   more skips the divide steps. s_axis_tready_o is high only while the
//   sequencer is idle.
// Stall:
//   The result sits in an output register; the next measurement is accepted
//   while it waits. A finished result holds the sequencer until the output
//   register is free.
// Reset:
//   Registers return to A = 1.0, H = 1.0, Q = 0, R = 3.0; the estimate
//   clears to 0 and the variance to 50.0. No output is pending.
`timescale 1ns / 1ps
`include "scalar_kalman_filter_core_defines.svh"

module scalar_kalman_filter_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [skf_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [skf_pkg::W-1:0]            cfg_wdata_i,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [skf_pkg::W-1:0]            s_axis_tdata_i,   // [31:0] measurement
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [3*skf_pkg::W-1:0]          m_axis_tdata_o    // estimate_out, variance_out,
                                                             // kalman_gain (low to high)
);
  import skf_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_XP_M, ST_XP_W, ST_A2_M, ST_A2_W, ST_PP_M, ST_PP_W, ST_PP_ADD,
    ST_H2_M, ST_H2_W, ST_S_M, ST_S_W, ST_S_ADD, ST_NUM_M, ST_NUM_W, ST_DIV_CHK,
    ST_DIV_RUN, ST_DIV_END, ST_HXP_M, ST_HXP_W, ST_INNOV, ST_CORR_M, ST_CORR_W,
    ST_X_ADD, ST_KH_M, ST_KH_W, ST_VAR_M, ST_VAR_W, ST_VAR_ADD, ST_OUT
  } state_e;

  function automatic logic [W-1:0] mag(logic [W-1:0] v);
    return v[W-1] ? (W'(0) - v) : v;
  endfunction

  function automatic logic [W-1:0] uadd_sat(logic [W-1:0] a, logic [W-1:0] b);
    logic [W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[W] ? UMAX : s[W-1:0];
  endfunction

  function automatic logic [W-1:0] sadd_sat(logic [W-1:0] a, logic [W-1:0] b, logic sub);
    logic [W:0] ax;
    logic [W:0] bx;
    logic [W:0] s;
    ax = {a[W-1], a};
    bx = {b[W-1], b};
    s  = sub ? (ax - bx) : (ax + bx);
    if (s[W] != s[W-1]) begin
      return s[W] ? SMIN : SMAX;
    end
    return s[W-1:0];
  endfunction

  state_e            state_q;
  logic [W-1:0]      a_q, h_q, qn_q, rn_q;
  logic [W-1:0]      est_q, var_q;
  logic              m_valid_q;
  logic [3*W-1:0]    m_data_q;

  // Datapath temporaries
  logic [W-1:0]      z_q, xp_q, a2_q, pp_q, h2_q, s_q, k_q;
  logic [W-1:0]      hxp_q, innov_q, corr_q, kh_q, m_q;
  logic [W-1:0]      rem_q, quo_q;
  logic [CNT_W-1:0]  cnt_q;

  // Shared multiplier
  logic [W-1:0]      mul_a, mul_b, mul_lim;
  logic              mul_neg;
  logic [2*W-1:0]    prod_q;
  logic              neg_q;
  logic [W-1:0]      lim_q;
  logic [2*W:0]      rsum;
  logic [RSH_W-1:0]  rsh;
  logic [W-1:0]      mres, sres;

  // Divider step and gain limits
  logic [W:0]        div_t;
  logic              div_ge;
  logic [W:0]        div_diff;
  logic [2*W-1:0]    num_sum;
  logic [W-1:0]      klim, kmag_end;
  logic [W-1:0]      var_sub;

  logic              in_acc, out_free;

  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  // Operand select for the shared multiplier
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    case (state_q)
      ST_XP_M: begin
        mul_a   = mag(a_q);
        mul_b   = mag(est_q);
        mul_neg = a_q[W-1] ^ est_q[W-1];
      end
      ST_A2_M: begin
        mul_a = mag(a_q);
        mul_b = mag(a_q);
      end
      ST_PP_M: begin
        mul_a = a2_q;
        mul_b = var_q;
      end
      ST_H2_M: begin
        mul_a = mag(h_q);
        mul_b = mag(h_q);
      end
      ST_S_M: begin
        mul_a = h2_q;
        mul_b = pp_q;
      end
      ST_NUM_M: begin
        mul_a = pp_q;
        mul_b = mag(h_q);
      end
      ST_HXP_M: begin
        mul_a   = mag(h_q);
        mul_b   = mag(xp_q);
        mul_neg = h_q[W-1] ^ xp_q[W-1];
      end
      ST_CORR_M: begin
        mul_a   = mag(k_q);
        mul_b   = mag(innov_q);
        mul_neg = k_q[W-1] ^ innov_q[W-1];
      end
      ST_KH_M: begin
        mul_a   = mag(k_q);
        mul_b   = mag(h_q);
        mul_neg = k_q[W-1] ^ h_q[W-1];
      end
      ST_VAR_M: begin
        mul_a = mag(kh_q);
        mul_b = pp_q;
      end
      default: begin
        mul_a = '0;
      end
    endcase
    // Signed products saturate to the signed range, variance terms to unsigned
    if (state_q == ST_XP_M || state_q == ST_HXP_M || state_q == ST_CORR_M ||
        state_q == ST_KH_M) begin
      mul_lim = mul_neg ? SMIN : SMAX;
    end else begin
      mul_lim = UMAX;
    end
  end

  // Round half away from zero on the magnitude, drop fraction bits, saturate
  always_comb begin
    rsum = {1'b0, prod_q} + RND_HALF;
    rsh  = rsum[2*W:F];
    mres = (rsh > RSH_W'(lim_q)) ? lim_q : rsh[W-1:0];
    sres = neg_q ? (W'(0) - mres) : mres;
  end

  always_comb begin
    div_t    = {rem_q, quo_q[W-1]};
    div_ge   = (div_t >= {1'b0, s_q});
    div_diff = div_t - {1'b0, s_q};
    num_sum  = prod_q + (2 * W)'(s_q >> 1);
    klim     = h_q[W-1] ? SMIN : SMAX;
    kmag_end = (quo_q > klim) ? klim : quo_q;
    var_sub  = (m_q > pp_q) ? '0 : (pp_q - m_q);
  end

  always_ff @(posedge clk_i) begin
    prod_q <= {{W{1'b0}}, mul_a} * {{W{1'b0}}, mul_b};
    neg_q  <= mul_neg;
    lim_q  <= mul_lim;
  end

  // Datapath registers, advanced by the sequencer
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          z_q <= s_axis_tdata_i;
        end
      end
      ST_XP_W:    xp_q <= sres;
      ST_A2_W:    a2_q <= mres;
      ST_PP_W:    pp_q <= mres;
      ST_PP_ADD:  pp_q <= uadd_sat(pp_q, qn_q);
      ST_H2_W:    h2_q <= mres;
      ST_S_W:     s_q  <= mres;
      ST_S_ADD:   s_q  <= uadd_sat(s_q, rn_q);
      ST_NUM_M: begin
        if (s_q == '0) begin
          k_q <= '0;
        end
      end
      ST_NUM_W: begin
        rem_q <= num_sum[2*W-1:W];
        quo_q <= num_sum[W-1:0];
      end
      ST_DIV_CHK: begin
        // Quotient of 2^W or more: gain saturates at once
        if (rem_q >= s_q) begin
          k_q <= klim;
        end
        cnt_q <= CNT_W'(W - 1);
      end
      ST_DIV_RUN: begin
        rem_q <= div_ge ? div_diff[W-1:0] : div_t[W-1:0];
        quo_q <= {quo_q[W-2:0], div_ge};
        cnt_q <= cnt_q - 1'b1;
      end
      ST_DIV_END: k_q     <= h_q[W-1] ? (W'(0) - kmag_end) : kmag_end;
      ST_HXP_W:   hxp_q   <= sres;
      ST_INNOV:   innov_q <= sadd_sat(z_q, hxp_q, 1'b1);
      ST_CORR_W:  corr_q  <= sres;
      ST_KH_W:    kh_q    <= sres;
      ST_VAR_W:   m_q     <= mres;
      default: begin
        cnt_q <= cnt_q;
      end
    endcase
  end

  // Sequencer, configuration, filter state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      a_q       <= A_RESET;
      h_q       <= H_RESET;
      qn_q      <= Q_RESET;
      rn_q      <= R_RESET;
      est_q     <= '0;
      var_q     <= VAR_RESET;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_addr_i))
          REG_TRANSITION: a_q  <= cfg_wdata_i;
          REG_MEASURE:    h_q  <= cfg_wdata_i;
          REG_PNOISE:     qn_q <= cfg_wdata_i;
          REG_MNOISE:     rn_q <= cfg_wdata_i;
          default:        a_q  <= a_q;
        endcase
      end

      // Drop the result once taken; in ST_OUT a new one replaces it below
      if (m_valid_q && m_axis_tready_i && state_q != ST_OUT) begin
        m_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            state_q <= ST_XP_M;
          end
        end
        ST_XP_M:   state_q <= ST_XP_W;
        ST_XP_W:   state_q <= ST_A2_M;
        ST_A2_M:   state_q <= ST_A2_W;
        ST_A2_W:   state_q <= ST_PP_M;
        ST_PP_M:   state_q <= ST_PP_W;
        ST_PP_W:   state_q <= ST_PP_ADD;
        ST_PP_ADD: state_q <= ST_H2_M;
        ST_H2_M:   state_q <= ST_H2_W;
        ST_H2_W:   state_q <= ST_S_M;
        ST_S_M:    state_q <= ST_S_W;
        ST_S_W:    state_q <= ST_S_ADD;
        ST_S_ADD:  state_q <= ST_NUM_M;
        ST_NUM_M:  state_q <= (s_q == '0) ? ST_HXP_M : ST_NUM_W;
        ST_NUM_W:  state_q <= ST_DIV_CHK;
        ST_DIV_CHK: begin
          state_q <= (rem_q >= s_q) ? ST_HXP_M : ST_DIV_RUN;
        end
        ST_DIV_RUN: begin
          if (cnt_q == '0) begin
            state_q <= ST_DIV_END;
          end
        end
        ST_DIV_END: state_q <= ST_HXP_M;
        ST_HXP_M:   state_q <= ST_HXP_W;
        ST_HXP_W:   state_q <= ST_INNOV;
        ST_INNOV:   state_q <= ST_CORR_M;
        ST_CORR_M:  state_q <= ST_CORR_W;
        ST_CORR_W:  state_q <= ST_X_ADD;
        ST_X_ADD: begin
          est_q   <= sadd_sat(xp_q, corr_q, 1'b0);
          state_q <= ST_KH_M;
        end
        ST_KH_M:  state_q <= ST_KH_W;
        ST_KH_W:  state_q <= ST_VAR_M;
        ST_VAR_M: state_q <= ST_VAR_W;
        ST_VAR_W: state_q <= ST_VAR_ADD;
        ST_VAR_ADD: begin
          // Negative gain product widens the variance; otherwise floor at zero
          var_q   <= kh_q[W-1] ? uadd_sat(pp_q, m_q) : var_sub;
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          // Hold here until the output register is free
          if (out_free) begin
            m_data_q  <= {k_q, var_q, est_q};
            m_valid_q <= 1'b1;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Checks
  `SKF_ASSERT(a_accept_leaves_idle, in_acc |=> (state_q == ST_XP_M), "accept did not start")
  `SKF_ASSERT(a_div_nonzero, (state_q == ST_DIV_RUN) |-> (s_q != '0), "divide by zero")
  `SKF_ASSERT(a_var_shrinks, (state_q == ST_VAR_ADD && !kh_q[W-1]) |=> (var_q <= pp_q), "var grew")
  `SKF_ASSERT(a_valid_from_out, $rose(m_valid_q) |-> ($past(state_q) == ST_OUT), "stray result")

endmodule

### test/scalar_kalman_filter_core_tb.sv
// Self-checking stream testbench for the scalar Kalman filter core.
`timescale 1ns / 1ps

module tb;
  import skf_pkg::*;

  localparam int UNIT       = 1 << F;      // 1.0 in the block's fixed point
  localparam int LONG_HOLD  = 300;         // cycles of the long result back-pressure
  localparam int DRAIN_WAIT = 70;          // a bit more than one measurement's latency
  localparam int LIMIT_NS   = 4_000_000;   // timeout for the whole run, in ns
  localparam int MAX_PRINTS = 40;

  typedef logic [2*W+1:0] wide_t;

  // Packed low to high as on m_axis_tdata_o: estimate, variance, gain.
  typedef struct packed {
    logic [W-1:0] gain;
    logic [W-1:0] variance;
    logic [W-1:0] estimate;
  } kf_result_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  cfg_reg_e cfg_addr_i = REG_TRANSITION;
  logic [W-1:0] cfg_wdata_i = '0;
  logic s_axis_tvalid_i = 1'b0;
  logic s_axis_tready_o;
  logic [W-1:0] s_axis_tdata_i = '0;     // [31:0] measurement
  logic m_axis_tvalid_o;
  logic m_axis_tready_i = 1'b0;
  logic [3*W-1:0] m_axis_tdata_o;        // [31:0] estimate, [63:32] variance, [95:64] gain

  scalar_kalman_filter_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Filter state and registers as the block should hold them.
  logic [W-1:0] gain_a, gain_h, noise_q, noise_r;
  logic [W-1:0] est_state, var_state;

  logic [W-1:0] meas_q[$];          // measurements waiting for the driver
  kf_result_t   update_q[$];        // expected filter updates, oldest first
  int unsigned  sent_count = 0;     // measurements handed to the driver
  int unsigned  done_count = 0;     // results received
  int unsigned  err_count = 0;

  logic src_taken = 1'b0, sink_taken = 1'b0;
  int   src_gap = 0, sink_gap = 0, sink_hold = 0;
  bit   src_steady = 1'b0, sink_steady = 1'b0;
  int unsigned results_seen = 0;

  // ---------------------------------------------------------------------------
  // Fixed-point arithmetic of the filter
  // ---------------------------------------------------------------------------

  function automatic logic [W-1:0] magnitude(input logic [W-1:0] v);
    return v[W-1] ? -v : v;
  endfunction

  // Magnitude product, round half away from zero, drop the fraction, clamp to lim.
  function automatic logic [W-1:0] mul_round(input logic [W-1:0] a, b, lim);
    wide_t prod;
    prod = (wide_t'(a) * wide_t'(b) + (wide_t'(1) << (F - 1))) >> F;
    return (prod > wide_t'(lim)) ? lim : prod[W-1:0];
  endfunction

  function automatic logic [W-1:0] smul_round(input logic [W-1:0] a, b);
    logic         neg;
    logic [W-1:0] m;
    neg = a[W-1] ^ b[W-1];
    m   = mul_round(magnitude(a), magnitude(b), neg ? SMIN : SMAX);
    return neg ? -m : m;
  endfunction

  function automatic logic [W-1:0] add_signed(input logic [W-1:0] a, b, input bit sub);
    logic signed [W+1:0] xa, xb, sum;
    xa  = $signed({{2{a[W-1]}}, a});
    xb  = $signed({{2{b[W-1]}}, b});
    sum = sub ? xa - xb : xa + xb;
    if (sum > $signed({2'b00, SMAX})) return SMAX;
    if (sum < $signed({2'b11, SMIN})) return SMIN;
    return sum[W-1:0];
  endfunction

  function automatic logic [W-1:0] add_unsigned(input logic [W-1:0] a, b);
    logic [W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[W] ? UMAX : sum[W-1:0];
  endfunction

  // One predict/correct step on measurement z from the current state.
  function automatic kf_result_t kalman_update(input logic [W-1:0] z);
    kf_result_t   res;
    logic [W-1:0] xp, a2, pp, h2, s, kmag, lim, k, hxp, innov, corr, kh, m;
    wide_t        num, quo;
    xp = smul_round(gain_a, est_state);
    a2 = mul_round(magnitude(gain_a), magnitude(gain_a), UMAX);
    pp = add_unsigned(mul_round(a2, var_state, UMAX), noise_q);
    h2 = mul_round(magnitude(gain_h), magnitude(gain_h), UMAX);
    s  = add_unsigned(mul_round(h2, pp, UMAX), noise_r);
    // zero innovation variance leaves the gain at zero
    k = '0;
    if (s != '0) begin
      num  = wide_t'(pp) * wide_t'(magnitude(gain_h)) + wide_t'(s >> 1);
      quo  = num / wide_t'(s);
      lim  = gain_h[W-1] ? SMIN : SMAX;
      kmag = (quo > wide_t'(lim)) ? lim : quo[W-1:0];
      k    = gain_h[W-1] ? -kmag : kmag;
    end
    hxp   = smul_round(gain_h, xp);
    innov = add_signed(z, hxp, 1'b1);
    corr  = smul_round(k, innov);
    res.estimate = add_signed(xp, corr, 1'b0);
    kh = smul_round(k, gain_h);
    m  = mul_round(magnitude(kh), pp, UMAX);
    // a correction larger than the predicted variance floors it at zero
    if (kh[W-1]) res.variance = add_unsigned(pp, m);
    else         res.variance = (m > pp) ? '0 : pp - m;
    res.gain = k;
    return res;
  endfunction

  task automatic report(input string what, input logic [W-1:0] got, input logic [W-1:0] want);
    if (err_count < MAX_PRINTS)
      $display("%0t ns: %s mismatch: got %h, want %h", $time, what, got, want);
    err_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Handshake flags, sampled at the rising edge for the falling-edge drivers
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_taken  <= 1'b0;
      sink_taken <= 1'b0;
    end else begin
      src_taken  <= s_axis_tvalid_i && s_axis_tready_o;
      sink_taken <= m_axis_tvalid_o && m_axis_tready_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Measurement driver: offer queued items with random idle gaps between
  // them, and stretches of back-to-back offers.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else if (!s_axis_tvalid_i || src_taken) begin
      if (src_gap > 0) begin
        src_gap--;
        s_axis_tvalid_i <= 1'b0;
      end else if (meas_q.size() > 0) begin
        s_axis_tdata_i  <= meas_q.pop_front();
        s_axis_tvalid_i <= 1'b1;
        if ($urandom_range(0, 99) < 4) src_steady = !src_steady;
        src_gap = src_steady ? 0 : $urandom_range(0, 5);
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result sink: stall at random after each result; now and then hold off
  // long enough that the core fills up and drops s_axis_tready_o.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (sink_taken) begin
        results_seen++;
        if (results_seen % 300 == 150) sink_hold = LONG_HOLD;
        if ($urandom_range(0, 99) < 4) sink_steady = !sink_steady;
        sink_gap = sink_steady ? 0 : $urandom_range(0, 5);
      end
      if (sink_hold > 0) begin
        sink_hold--;
        m_axis_tready_i <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each result against the oldest expectation, then predict
  // for any accepted measurement and track register writes.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    kf_result_t got, want;
    if (!rst_ni) begin
      gain_a    = A_RESET;
      gain_h    = H_RESET;
      noise_q   = Q_RESET;
      noise_r   = R_RESET;
      est_state = '0;
      var_state = VAR_RESET;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = kf_result_t'(m_axis_tdata_o);
        done_count++;
        if (update_q.size() == 0) begin
          report("unexpected result, estimate", got.estimate, '0);
        end else begin
          want = update_q.pop_front();
          if (got.estimate !== want.estimate) report("estimate", got.estimate, want.estimate);
          if (got.variance !== want.variance) report("variance", got.variance, want.variance);
          if (got.gain !== want.gain)         report("gain", got.gain, want.gain);
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        want = kalman_update(s_axis_tdata_i);
        est_state = want.estimate;
        var_state = want.variance;
        update_q = {update_q, want};
      end
      if (cfg_we_i) begin
        case (cfg_addr_i)
          REG_TRANSITION: gain_a  = cfg_wdata_i;
          REG_MEASURE:    gain_h  = cfg_wdata_i;
          REG_PNOISE:     noise_q = cfg_wdata_i;
          REG_MNOISE:     noise_r = cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Hold until every handed-off measurement has produced its result.
  task automatic wait_idle();
    @(negedge clk_i);
    while (!(done_count == sent_count && s_axis_tready_o)) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
  endtask

  task automatic set_regs(input logic [W-1:0] a, h, q, r);
    wait_idle();
    write_reg(REG_TRANSITION, a);
    write_reg(REG_MEASURE, h);
    write_reg(REG_PNOISE, q);
    write_reg(REG_MNOISE, r);
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_meas(input logic [W-1:0] z);
    meas_q = {meas_q, z};
    sent_count++;
  endtask

  // Mostly plausible gains near 1.0, sometimes negative, zero, extreme or raw.
  function automatic logic [W-1:0] pick_gain();
    logic [W-1:0] g;
    g = W'(UNIT * 3 / 4 + $urandom_range(0, UNIT / 2));
    case ($urandom_range(0, 9))
      6:       return -g;
      7:       return $urandom;
      8:       return $urandom_range(0, 1) ? SMAX : SMIN;
      9:       return '0;
      default: return g;
    endcase
  endfunction

  function automatic logic [W-1:0] pick_noise();
    case ($urandom_range(0, 9))
      6:       return $urandom;
      7:       return UMAX;
      8:       return '0;
      9:       return $urandom_range(0, 255);
      default: return $urandom_range(0, 8 * UNIT);
    endcase
  endfunction

  initial begin
    int track, sel, random_sent;
    rst_ni = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset registers: extremes of the measurement.
    push_meas('0);
    push_meas(W'(1));
    push_meas(UMAX);
    push_meas(SMAX);
    push_meas(SMIN);
    push_meas(W'(10 * UNIT));
    push_meas(W'(-10 * UNIT));

    // No measurement gain and no measurement noise: zero denominator.
    set_regs(ONE_Q, '0, '0, '0);
    repeat (3) push_meas(W'(5 * UNIT));

    // Zero predicted variance with no noise: zero denominator again.
    set_regs('0, ONE_Q, '0, '0);
    repeat (3) push_meas($urandom);

    // Largest gains and noises: everything saturates.
    set_regs(SMAX, SMIN, UMAX, UMAX);
    push_meas(SMAX);
    push_meas(SMIN);
    push_meas('0);

    // Saturated H*H against zero noise: gain overshoot, variance floors at zero.
    set_regs(SMIN, SMAX, '0, '0);
    push_meas(SMIN);
    push_meas(SMAX);
    push_meas(W'(UNIT));

    // Back to plain settings with a small R.
    set_regs(A_RESET, H_RESET, W'(UNIT / 16), W'(1));
    repeat (3) push_meas(SMAX);

    // Random phases: a drifting true value with noise, plus raw and extreme items.
    random_sent = 0;
    while (random_sent < 1800) begin
      if ($urandom_range(0, 3) == 0)
        set_regs(A_RESET, H_RESET, pick_noise(), pick_noise());
      else
        set_regs(pick_gain(), pick_gain(), pick_noise(), pick_noise());
      track = int'($urandom_range(0, 200 * UNIT)) - 100 * UNIT;
      repeat (150) begin
        sel   = $urandom_range(0, 99);
        track = track + int'($urandom_range(0, 2 * UNIT)) - UNIT;
        if (sel < 8)
          push_meas($urandom);
        else if (sel < 10)
          push_meas(sel == 8 ? SMAX : SMIN);
        else
          push_meas(W'(track + int'($urandom_range(0, 8 * UNIT)) - 4 * UNIT));
        random_sent++;
      end
    end

    // Drain, then allow for any stray result.
    wait_idle();
    repeat (DRAIN_WAIT) @(negedge clk_i);
    if (err_count == 0 && update_q.size() == 0) begin
      $display("scalar_kalman_filter_core regression: pass");
    end else begin
      $display("scalar_kalman_filter_core regression: fail");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("%0t ns: timeout, %0d of %0d results received", $time, done_count, sent_count);
    $display("scalar_kalman_filter_core regression: fail");
    $finish;
  end

endmodule
